/* rtl/msd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msd_pkg
// Shared types and constants for the track-2 magnetic-stripe decoder.
// ----------------------------------------------------------------------------
package msd_pkg;

  // Largest number of bits stored for one card before it is rejected
  localparam int MAX_BITS  = 256;
  localparam int BITS_W    = $clog2(MAX_BITS + 1);

  localparam int CHAR_BITS = 5;
  localparam int IDX_W     = $clog2(CHAR_BITS + 1);

  localparam logic [4:0]  END_CODE    = 5'h1F;
  localparam logic [15:0] TIMEOUT_RST = 16'd500;
  localparam logic [4:0]  START_RST   = 5'd11;

  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  // Register word index (byte address / 4)
  typedef enum logic [0:0] {
    REG_TIMEOUT = 1'b0,
    REG_START   = 1'b1
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE    = 2'd0,
    ST_READING = 2'd1,
    ST_ACCEPT  = 2'd2,
    ST_REJECT  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CAUSE_PARITY   = 2'd0,
    CAUSE_LRC      = 2'd1,
    CAUSE_TIMEOUT  = 2'd2,
    CAUSE_OVERFLOW = 2'd3
  } cause_t;

  typedef enum logic {
    PH_IDLE    = 1'b0,
    PH_READING = 1'b1
  } phase_t;

  typedef struct packed {
    logic [15:0] timeout_ticks;
    logic [4:0]  start_code;
  } cfg_t;

  typedef struct packed {
    logic func;
    logic line_bit;
  } in_t;

  typedef struct packed {
    logic [1:0] status;
    logic       char_valid;
    logic [3:0] char_value;
    logic [1:0] reject_cause;
  } out_t;

endpackage

/* rtl/msd_cfg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msd_cfg
// APB-style register file: timeout_ticks and start_code.
// ----------------------------------------------------------------------------
module msd_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [msd_pkg::ADDR_W-1:0]  paddr,
  input  logic [msd_pkg::DATA_W-1:0]  pwdata,
  output logic [msd_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output msd_pkg::cfg_t               cfg
);

  msd_pkg::cfg_t cfg_r;
  msd_pkg::cfg_t cfg_nxt;
  logic          wr_en;
  logic          idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign idx    = paddr[2];

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        msd_pkg::REG_TIMEOUT: cfg_nxt.timeout_ticks = pwdata[15:0];
        msd_pkg::REG_START:   cfg_nxt.start_code    = pwdata[4:0];
        default:              cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.timeout_ticks <= msd_pkg::TIMEOUT_RST;
      cfg_r.start_code    <= msd_pkg::START_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    case (idx)
      msd_pkg::REG_TIMEOUT: prdata = {{(msd_pkg::DATA_W-16){1'b0}}, cfg_r.timeout_ticks};
      msd_pkg::REG_START:   prdata = {{(msd_pkg::DATA_W-5){1'b0}}, cfg_r.start_code};
      default:              prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

/* rtl/msd_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msd_core
// Decoder state and the single-pass update for one transaction.
// ----------------------------------------------------------------------------
module msd_core (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          adv,
  input  msd_pkg::in_t  item,
  input  msd_pkg::cfg_t cfg,
  output msd_pkg::out_t res
);

  msd_pkg::phase_t                 phase_r, phase_nxt;
  logic [4:0]                      window_r, window_nxt;
  logic [msd_pkg::IDX_W-1:0]       index_r, index_nxt;
  logic [3:0]                      lrc_r, lrc_nxt;
  logic [msd_pkg::BITS_W-1:0]      stored_r, stored_nxt;
  logic [15:0]                     countdown_r, countdown_nxt;
  logic                            after_end_r, after_end_nxt;

  logic                            bit_true;
  logic [4:0]                      win_sh;
  logic                            match;
  logic                            ovf;
  logic [msd_pkg::IDX_W-1:0]       index_inc;
  logic                            char_done;
  logic                            par_ok;
  logic                            lrc_ok;
  logic                            is_end;
  logic                            expired;
  logic                            do_idle;

  assign bit_true  = ~item.line_bit;
  assign win_sh    = {bit_true, window_r[4:1]};
  assign match     = !item.func && (win_sh == cfg.start_code);
  assign ovf       = stored_r >= msd_pkg::BITS_W'(msd_pkg::MAX_BITS);
  assign index_inc = index_r + 1'b1;
  assign char_done = index_inc >= msd_pkg::IDX_W'(msd_pkg::CHAR_BITS);
  assign par_ok    = ^win_sh;
  assign lrc_ok    = (lrc_r ^ win_sh[3:0]) == 4'd0;
  assign is_end    = win_sh == msd_pkg::END_CODE;
  assign expired   = countdown_r <= 16'd1;

  // Next state
  always_comb begin
    phase_nxt     = phase_r;
    window_nxt    = window_r;
    index_nxt     = index_r;
    lrc_nxt       = lrc_r;
    stored_nxt    = stored_r;
    countdown_nxt = countdown_r;
    after_end_nxt = after_end_r;
    do_idle       = 1'b0;
    if (adv) begin
      if (phase_r != msd_pkg::PH_READING) begin
        if (!item.func) begin
          window_nxt = win_sh;
          if (match) begin
            phase_nxt     = msd_pkg::PH_READING;
            lrc_nxt       = cfg.start_code[3:0];
            stored_nxt    = msd_pkg::BITS_W'(msd_pkg::CHAR_BITS);
            index_nxt     = '0;
            window_nxt    = '0;
            after_end_nxt = 1'b0;
            countdown_nxt = cfg.timeout_ticks;
          end
        end
      end else if (item.func) begin
        if (expired) begin
          do_idle = 1'b1;
        end else begin
          countdown_nxt = countdown_r - 16'd1;
        end
      end else begin
        countdown_nxt = cfg.timeout_ticks;
        if (ovf) begin
          do_idle = 1'b1;
        end else begin
          stored_nxt = stored_r + 1'b1;
          window_nxt = win_sh;
          index_nxt  = index_inc;
          if (char_done) begin
            window_nxt = '0;
            index_nxt  = '0;
            if (!par_ok || after_end_r) begin
              do_idle = 1'b1;
            end else begin
              lrc_nxt = lrc_r ^ win_sh[3:0];
              if (is_end) begin
                after_end_nxt = 1'b1;
              end
            end
          end
        end
      end
      if (do_idle) begin
        phase_nxt     = msd_pkg::PH_IDLE;
        window_nxt    = '0;
        index_nxt     = '0;
        lrc_nxt       = '0;
        stored_nxt    = '0;
        after_end_nxt = 1'b0;
      end
    end
  end

  // Result of the current transaction
  always_comb begin
    res.status       = msd_pkg::ST_IDLE;
    res.char_valid   = 1'b0;
    res.char_value   = 4'd0;
    res.reject_cause = msd_pkg::CAUSE_PARITY;
    if (phase_r != msd_pkg::PH_READING) begin
      if (match) begin
        res.status = msd_pkg::ST_READING;
      end
    end else if (item.func) begin
      if (expired) begin
        res.status       = msd_pkg::ST_REJECT;
        res.reject_cause = msd_pkg::CAUSE_TIMEOUT;
      end else begin
        res.status = msd_pkg::ST_READING;
      end
    end else if (ovf) begin
      res.status       = msd_pkg::ST_REJECT;
      res.reject_cause = msd_pkg::CAUSE_OVERFLOW;
    end else begin
      res.status = msd_pkg::ST_READING;
      if (char_done) begin
        if (!par_ok) begin
          res.status       = msd_pkg::ST_REJECT;
          res.reject_cause = msd_pkg::CAUSE_PARITY;
        end else if (after_end_r) begin
          if (lrc_ok) begin
            res.status = msd_pkg::ST_ACCEPT;
          end else begin
            res.status       = msd_pkg::ST_REJECT;
            res.reject_cause = msd_pkg::CAUSE_LRC;
          end
        end else if (!is_end) begin
          res.char_valid = 1'b1;
          res.char_value = win_sh[3:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= msd_pkg::PH_IDLE;
      window_r    <= '0;
      index_r     <= '0;
      lrc_r       <= '0;
      stored_r    <= '0;
      countdown_r <= msd_pkg::TIMEOUT_RST;
      after_end_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      window_r    <= window_nxt;
      index_r     <= index_nxt;
      lrc_r       <= lrc_nxt;
      stored_r    <= stored_nxt;
      countdown_r <= countdown_nxt;
      after_end_r <= after_end_nxt;
    end
  end

endmodule

/* rtl/magstripe_track2_decoder_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// magstripe_track2_decoder_top
// Track-2 magnetic-stripe decoder: start-sentinel search, character framing,
// parity, LRC, timeout and overflow checks; one result per transaction.
// ----------------------------------------------------------------------------
// Pipeline: an accepted input transaction passes from the input register
//   through the single-pass update into the result register.
// Throughput: one transaction per cycle while the result channel is not stalled.
// Reset: rst_n is synchronous, active low; it empties both register stages,
//   returns the decoder to idle and loads timeout_ticks = 500, start_code = 11.
// ----------------------------------------------------------------------------
module magstripe_track2_decoder_top (
  input  logic                        clk,
  input  logic                        rst_n,
  // input channel
  input  logic                        in_valid,
  output logic                        in_stall,
  input  msd_pkg::in_t                in_data,
  // result channel
  output logic                        out_valid,
  input  logic                        out_stall,
  output msd_pkg::out_t               out_data,
  // configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [msd_pkg::ADDR_W-1:0]  paddr,
  input  logic [msd_pkg::DATA_W-1:0]  pwdata,
  output logic [msd_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);

  msd_pkg::cfg_t cfg;
  msd_pkg::out_t res;

  logic          in_vld_r, in_vld_nxt;
  msd_pkg::in_t  in_data_r;
  logic          out_vld_r, out_vld_nxt;
  msd_pkg::out_t out_data_r;
  logic          in_acc;
  logic          adv;

  msd_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Advance the held transaction whenever the result register is free or
  // being drained this cycle.
  assign adv      = in_vld_r && (!out_vld_r || !out_stall);
  // Hold off the sender only while a transaction sits blocked in the input
  // register; a waiting result alone does not stop intake.
  assign in_stall = in_vld_r && !adv;
  assign in_acc   = in_valid && !in_stall;

  msd_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .item  (in_data_r),
    .cfg   (cfg),
    .res   (res)
  );

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_acc) begin
      in_vld_nxt = 1'b1;
    end else if (adv) begin
      in_vld_nxt = 1'b0;
    end
  end

  // Keep the result while stalled, load it on advance, drop it once taken.
  assign out_vld_nxt = adv || (out_vld_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_data_r <= in_data;
    end
    if (adv) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // A transaction that advances shows up as a result on the next cycle.
  a_adv_delivers: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_valid)
    else $error("advanced transaction did not reach the result register");

  // Intake stalls only when a blocked result backs up the pipeline.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a blocked result");

  // Data characters are only reported while reading.
  a_char_reading: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.char_valid) |-> (out_data.status == msd_pkg::ST_READING))
    else $error("character reported outside of reading");

  // Cause is zero unless the card was rejected.
  a_cause_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status != msd_pkg::ST_REJECT)
      |-> (out_data.reject_cause == msd_pkg::CAUSE_PARITY))
    else $error("reject cause set without a reject");

endmodule
